[sv/ibpf_pkg.sv]
package ibpf_pkg;

  // Operand word: Q16.16 history value, input samples padded with 16 zero fraction bits.
  localparam int OPND_W  = 32;
  localparam int SAMP_W  = 16;
  localparam int Y_FRAC  = 16;
  localparam int DIG_W   = 4;
  localparam int N_DIG   = OPND_W / DIG_W;
  localparam int ACC_W   = 64;
  localparam int INT_BITS = 6;
  localparam int TAB_LEN = 17;

  localparam longint unsigned DEC_SCALE = 64'd1000000000;

  // Coefficients in units of 1e-9; entries past index 9 are zero.
  localparam longint X_DEC [TAB_LEN] = '{
    64'sd1219565, 64'sd8536952, 64'sd24391290, 64'sd34147810, 64'sd17073900,
    -64'sd17073900, -64'sd34147810, -64'sd24391290, -64'sd8536952, -64'sd1219565,
    64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0
  };
  localparam longint Y_DEC [TAB_LEN] = '{
    64'sd0, -64'sd3179958000, 64'sd5166898000, -64'sd5512706000, 64'sd4023904000,
    -64'sd2096830000, 64'sd759568500, -64'sd185368900, 64'sd27223280, -64'sd1840134,
    64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_RND,
    ST_OUT
  } state_t;

  // Converts a decimal coefficient to fixed point with frac fraction bits,
  // rounding to nearest with ties away from zero. Used at elaboration only.
  function automatic longint to_fixed(input longint dec, input int frac);
    longint unsigned mag;
    longint unsigned res;
    longint unsigned rem;
    mag = (dec < 0) ? longint'(-dec) : longint'(dec);
    res = mag / DEC_SCALE;
    rem = mag % DEC_SCALE;
    for (int i = 0; i < frac; i++) begin
      res = res << 1;
      rem = rem << 1;
      if (rem >= DEC_SCALE) begin
        rem = rem - DEC_SCALE;
        res = res | 64'd1;
      end
    end
    rem = rem << 1;
    if (rem >= DEC_SCALE) begin
      res = res + 64'd1;
    end
    return (dec < 0) ? -longint'(res) : longint'(res);
  endfunction

endpackage

[sv/iir_band_pass_filter.sv]
// Ninth-order direct-form-I IIR band-pass filter (10 Hz high pass, 3 kHz low pass)
// for 16-bit audio. A request on the input channel (in_valid high, in_stall low)
// carries one signed sample in in_sample_in; each request yields exactly one
// result request on the output channel with the saturated sample and a clip flag.
// All products go through a single shared digit-serial multiplier: the 32-bit
// operand is shifted through four bits per cycle against a parallel coefficient,
// and each finished product is then folded into the accumulator in its own step.
// A result takes 2*FILTER_ORDER+1 products and two rounding steps (ST_RND and
// ST_OUT); a new request is taken only once the previous result has been
// written to the output register and the sequencer is back in idle.
// in_stall stays high while a sample is being processed. The result sits in an
// output register; a stalled receiver holds it there, and the next sample is still
// taken and computed, but its result waits until the register is free.
// Synchronous active-low reset clears both histories and drops any pending result.
module iir_band_pass_filter #(
  parameter int FILTER_ORDER = 9,
  parameter int COEF_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_sample_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_sample_out,
  output logic        out_clipped
);
  import ibpf_pkg::*;

  localparam int CW        = COEF_WIDTH;
  localparam int COEF_FRAC = COEF_WIDTH - INT_BITS;
  // Partial sum of the serial multiplier: coefficient times one signed digit.
  localparam int PS_W      = CW + DIG_W + 1;
  localparam int TERM_W    = PS_W + Y_FRAC;
  localparam int RSH       = COEF_FRAC - Y_FRAC;
  localparam int NW        = (FILTER_ORDER + 1 > 1) ? $clog2(FILTER_ORDER + 1) : 1;
  localparam int DCW       = $clog2(N_DIG);

  // Coefficient tables, folded to constants at elaboration.
  logic signed [CW-1:0] xc_tab [FILTER_ORDER+1];
  logic signed [CW-1:0] yc_tab [FILTER_ORDER+1];

  for (genvar g = 0; g <= FILTER_ORDER; g++) begin : g_coef
    assign xc_tab[g] = COEF_WIDTH'(to_fixed(X_DEC[g], COEF_FRAC));
    assign yc_tab[g] = COEF_WIDTH'(to_fixed(Y_DEC[g], COEF_FRAC));
  end

  state_t state_r, state_nxt;

  logic [OPND_W-1:0]       op_r, op_nxt;
  logic signed [CW-1:0]    coef_r, coef_nxt;
  logic signed [PS_W-1:0]  s_r, s_nxt;
  logic [Y_FRAC-1:0]       low_r, low_nxt;
  logic [DCW-1:0]          dig_r, dig_nxt;
  logic [NW-1:0]           n_r, n_nxt;
  logic                    is_y_r, is_y_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [SAMP_W-1:0]       x_r, x_nxt;
  logic [OPND_W-1:0]       y_r, y_nxt;
  logic [SAMP_W-1:0]       xh_r [FILTER_ORDER];
  logic [SAMP_W-1:0]       xh_nxt [FILTER_ORDER];
  logic [OPND_W-1:0]       yh_r [FILTER_ORDER];
  logic [OPND_W-1:0]       yh_nxt [FILTER_ORDER];
  logic [SAMP_W-1:0]       out_sample_r, out_sample_nxt;
  logic                    out_clipped_r, out_clipped_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Control strobes decoded from the state.
  logic in_take;
  logic mul_en;
  logic acc_en;
  logic rnd_en;
  logic out_wr;
  logic out_free;

  logic last_dig;
  logic last_term;
  logic next_is_x;

  logic signed [DIG_W:0]     dig_s;
  logic signed [PS_W-1:0]    prod;
  logic signed [PS_W-1:0]    psum;
  logic signed [TERM_W-1:0]  term;
  logic signed [ACC_W-1:0]   rnd_sum;
  logic signed [ACC_W-1:0]   y_wide;
  logic                      y_ovf;
  logic [OPND_W-1:0]         y_sat;
  logic [OPND_W:0]           o_sum;
  logic [SAMP_W:0]           o_wide;
  logic                      o_clip;

  assign out_free  = !out_valid_r || !out_stall;
  assign last_dig  = (dig_r == DCW'(N_DIG - 1));
  assign last_term = is_y_r && (n_r == NW'(FILTER_ORDER));
  // After the current-sample term and after every feedback term, the next
  // product is an input-history term.
  assign next_is_x = (n_r == '0) || is_y_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (last_dig) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        state_nxt = last_term ? ST_RND : ST_MUL;
      end
      ST_RND: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_stall = 1'b1;
    in_take  = 1'b0;
    mul_en   = 1'b0;
    acc_en   = 1'b0;
    rnd_en   = 1'b0;
    out_wr   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        in_take  = in_valid;
      end
      ST_MUL: begin
        mul_en = 1'b1;
      end
      ST_ACC: begin
        acc_en = 1'b1;
      end
      ST_RND: begin
        rnd_en = 1'b1;
      end
      ST_OUT: begin
        out_wr = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Serial multiplier step: the lowest digit of the operand times the coefficient.
  // Lower digits are unsigned; the top digit carries the operand's sign.
  assign dig_s = {last_dig & op_r[DIG_W-1], op_r[DIG_W-1:0]};
  assign prod  = coef_r * dig_s;
  assign psum  = s_r + prod;

  // Product floored by 16 fraction bits: upper partial sum plus the last four
  // digits that were shifted out.
  assign term = {s_r, low_r};

  // Accumulator to Q16.16 with round half up, then saturation to 32 bits.
  assign rnd_sum = acc_r + (ACC_W'(1) <<< (RSH - 1));
  assign y_wide  = rnd_sum >>> RSH;
  assign y_ovf   = !((&y_wide[ACC_W-1:OPND_W-1]) || !(|y_wide[ACC_W-1:OPND_W-1]));
  assign y_sat   = y_ovf ? {y_wide[ACC_W-1], {(OPND_W-1){!y_wide[ACC_W-1]}}}
                         : y_wide[OPND_W-1:0];

  // Q16.16 to integer with round half up, then saturation to 16 bits.
  assign o_sum  = {y_r[OPND_W-1], y_r} + (OPND_W+1)'(1 << (Y_FRAC - 1));
  assign o_wide = o_sum[OPND_W:Y_FRAC];
  assign o_clip = o_wide[SAMP_W] != o_wide[SAMP_W-1];

  always_comb begin
    op_nxt          = op_r;
    coef_nxt        = coef_r;
    s_nxt           = s_r;
    low_nxt         = low_r;
    dig_nxt         = dig_r;
    n_nxt           = n_r;
    is_y_nxt        = is_y_r;
    acc_nxt         = acc_r;
    x_nxt           = x_r;
    y_nxt           = y_r;
    xh_nxt          = xh_r;
    yh_nxt          = yh_r;
    out_sample_nxt  = out_sample_r;
    out_clipped_nxt = out_clipped_r;
    out_valid_nxt   = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (in_take) begin
      // First product: the new sample with the leading feedforward tap.
      x_nxt    = in_sample_in;
      op_nxt   = {in_sample_in, {Y_FRAC{1'b0}}};
      coef_nxt = xc_tab[0];
      n_nxt    = '0;
      is_y_nxt = 1'b0;
      acc_nxt  = '0;
      s_nxt    = '0;
      dig_nxt  = '0;
    end

    if (mul_en) begin
      s_nxt   = psum >>> DIG_W;
      low_nxt = {psum[DIG_W-1:0], low_r[Y_FRAC-1:DIG_W]};
      op_nxt  = op_r >> DIG_W;
      dig_nxt = dig_r + DCW'(1);
    end

    if (acc_en) begin
      acc_nxt = is_y_r ? (acc_r - term) : (acc_r + term);
      s_nxt   = '0;
      dig_nxt = '0;
      // The histories rotate by one at each use, so the next tap is always at
      // the head; after a full pass they are back in place.
      if (!last_term) begin
        if (next_is_x) begin
          n_nxt    = n_r + NW'(1);
          is_y_nxt = 1'b0;
          coef_nxt = xc_tab[n_r + NW'(1)];
          op_nxt   = {xh_r[0], {Y_FRAC{1'b0}}};
          for (int i = 0; i < FILTER_ORDER - 1; i++) begin
            xh_nxt[i] = xh_r[i+1];
          end
          xh_nxt[FILTER_ORDER-1] = xh_r[0];
        end else begin
          is_y_nxt = 1'b1;
          coef_nxt = yc_tab[n_r];
          op_nxt   = yh_r[0];
          for (int i = 0; i < FILTER_ORDER - 1; i++) begin
            yh_nxt[i] = yh_r[i+1];
          end
          yh_nxt[FILTER_ORDER-1] = yh_r[0];
        end
      end
    end

    if (rnd_en) begin
      y_nxt = y_sat;
    end

    if (out_wr) begin
      for (int i = FILTER_ORDER - 1; i > 0; i--) begin
        xh_nxt[i] = xh_r[i-1];
        yh_nxt[i] = yh_r[i-1];
      end
      xh_nxt[0]       = x_r;
      yh_nxt[0]       = y_r;
      out_sample_nxt  = o_clip ? {o_wide[SAMP_W], {(SAMP_W-1){!o_wide[SAMP_W]}}}
                               : o_wide[SAMP_W-1:0];
      out_clipped_nxt = o_clip;
      out_valid_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FILTER_ORDER; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      xh_r        <= xh_nxt;
      yh_r        <= yh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    coef_r        <= coef_nxt;
    s_r           <= s_nxt;
    low_r         <= low_nxt;
    dig_r         <= dig_nxt;
    n_r           <= n_nxt;
    is_y_r        <= is_y_nxt;
    acc_r         <= acc_nxt;
    x_r           <= x_nxt;
    y_r           <= y_nxt;
    out_sample_r  <= out_sample_nxt;
    out_clipped_r <= out_clipped_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  // The block is built at its default order. The filter taps are listed below in
  // units of 1e-9 and turned into Q5.26 words at the start of the run.
  localparam int ORDER          = 9;
  localparam int COEF_FRAC      = 26;
  localparam int ACC_TO_Y       = COEF_FRAC - 16;
  localparam longint NANO       = 64'sd1000000000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int N_PHASES       = 4;

  // The idle mix of each random phase, in percent: no idling, a sparse sender,
  // a slow receiver, and both at once.
  localparam int TX_IDLE_PCT  [N_PHASES] = '{0, 86, 0, 38};
  localparam int RX_STALL_PCT [N_PHASES] = '{0, 0, 86, 38};

  localparam longint FEED_NANO [0:ORDER] = '{
    64'sd1219565, 64'sd8536952, 64'sd24391290, 64'sd34147810, 64'sd17073900,
    -64'sd17073900, -64'sd34147810, -64'sd24391290, -64'sd8536952, -64'sd1219565
  };
  localparam longint BACK_NANO [0:ORDER] = '{
    64'sd0, -64'sd3179958000, 64'sd5166898000, -64'sd5512706000, 64'sd4023904000,
    -64'sd2096830000, 64'sd759568500, -64'sd185368900, 64'sd27223280, -64'sd1840134
  };

  // Shapes of the random sample bursts.
  typedef enum int {
    PAT_NOISE,
    PAT_SQUARE,
    PAT_FULL_SQUARE,
    PAT_IMPULSE,
    PAT_QUIET,
    PAT_DC
  } pattern_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               clipped;
  } filt_result_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [15:0] in_sample_in   = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [15:0] out_sample_out;
  logic        out_clipped;

  // Our own copy of the filter: Q5.26 taps, the past inputs, and the past
  // outputs in Q16.16.
  longint             feed_tap [0:ORDER];
  longint             back_tap [0:ORDER];
  logic signed [15:0] x_hist [ORDER];
  logic signed [31:0] y_hist [ORDER];

  logic [15:0]  pending_samples [$];
  filt_result_t expected_filtered [$];
  filt_result_t head_result;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit want_hold    = 1'b0;
  int hold_cnt     = 0;
  int errors       = 0;
  int quiet_cycles = 0;

  iir_band_pass_filter #(
    .FILTER_ORDER(ORDER),
    .COEF_WIDTH  (COEF_FRAC + 6)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .out_clipped   (out_clipped)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scales a tap given in units of 1e-9 by 2^26 and rounds to nearest, with
  // ties going away from zero: floor(|c| * 2^26 / 1e9 + 1/2).
  function automatic longint to_q26(input longint nano);
    longint unsigned mag;
    longint unsigned q;
    mag = (nano < 0) ? longint'(-nano) : longint'(nano);
    q = ((mag << (COEF_FRAC + 1)) + NANO) / (2 * NANO);
    return (nano < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Runs one sample through the filter and advances the histories. Input
  // products are exact; feedback products are floored back to 26 fraction
  // bits. The sum is rounded half up to Q16.16 and clamped to 32 bits before
  // it is stored, so a runaway history saturates rather than wraps. The output
  // is that value rounded half up to an integer and clamped to 16 bits.
  function automatic filt_result_t filter_sample(input logic signed [15:0] x);
    longint       acc;
    longint       yq;
    longint       oq;
    filt_result_t r;
    acc = feed_tap[0] * longint'(x);
    for (int n = 1; n <= ORDER; n++) begin
      acc += feed_tap[n] * longint'(x_hist[n - 1]);
      acc -= (back_tap[n] * longint'(y_hist[n - 1])) >>> 16;
    end
    yq = (acc + (64'sd1 <<< (ACC_TO_Y - 1))) >>> ACC_TO_Y;
    if (yq > 64'sd2147483647) yq = 64'sd2147483647;
    if (yq < -64'sd2147483648) yq = -64'sd2147483648;
    for (int n = ORDER - 1; n > 0; n--) begin
      x_hist[n] = x_hist[n - 1];
      y_hist[n] = y_hist[n - 1];
    end
    x_hist[0] = x;
    y_hist[0] = yq[31:0];
    oq = (yq + 64'sd32768) >>> 16;
    r.clipped = 1'b0;
    if (oq > 64'sd32767) begin
      oq = 64'sd32767;
      r.clipped = 1'b1;
    end
    if (oq < -64'sd32768) begin
      oq = -64'sd32768;
      r.clipped = 1'b1;
    end
    r.sample = oq[15:0];
    return r;
  endfunction

  // Queues count samples as a string of bursts. Full-scale square waves near
  // the pass band build up past full scale and drive the output into
  // saturation; noise bursts toggle every bit of the sample; quiet stretches
  // and impulses let the filter ring down.
  task automatic queue_program(input int count);
    pattern_t    pat;
    int          len;
    int          amp;
    int          period;
    logic [15:0] s;
    while (count > 0) begin
      pat = pattern_t'($urandom_range(PAT_DC));
      if (pat == PAT_SQUARE || pat == PAT_FULL_SQUARE) begin
        len = $urandom_range(20, 120);
      end else begin
        len = $urandom_range(4, 40);
      end
      if (len > count) len = count;
      amp    = $urandom_range(32767);
      period = $urandom_range(2, 40);
      for (int i = 0; i < len; i++) begin
        case (pat)
          PAT_NOISE: begin
            s = 16'($urandom);
          end
          PAT_SQUARE: begin
            s = ((i % period) < period / 2) ? 16'(amp) : 16'(-amp);
          end
          PAT_FULL_SQUARE: begin
            s = ((i % period) < period / 2) ? 16'h7fff : 16'h8000;
          end
          PAT_IMPULSE: begin
            s = (i != 0) ? 16'h0000 : (amp[0] ? 16'h7fff : 16'h8000);
          end
          PAT_QUIET: begin
            s = 16'($urandom_range(64)) - 16'd32;
          end
          default: begin
            s = 16'(amp - 16384);
          end
        endcase
        pending_samples.push_back(s);
      end
      count -= len;
    end
  endtask

  // Returns once every queued sample has been taken and every result is back.
  // It looks at the falling edge, where nothing is changing.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_filtered.size() != 0);
  endtask

  // Sender. A request stays up, with its sample unchanged, until the block
  // takes it. Each taken sample is run through the predictor right away, so
  // the expected results line up in request order.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_sample_in <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_filtered.push_back(filter_sample(in_sample_in));
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid     <= 1'b1;
          in_sample_in <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Every result request that gets through is checked against the
  // oldest expected one. Once want_hold goes up, the receiver first holds off
  // for HOLD_CYCLES so that the block's output register and its working sample
  // both fill and the block stalls the sender; after that it stalls at the
  // rate of the current phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_filtered.size() == 0) begin
          $display("%0t: result with none expected: sample_out %0d, clipped %0b",
                   $time, $signed(out_sample_out), out_clipped);
          errors++;
        end else begin
          head_result = expected_filtered.pop_front();
          if (out_sample_out !== head_result.sample) begin
            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                     $time, head_result.sample, $signed(out_sample_out));
            errors++;
          end
          if (out_clipped !== head_result.clipped) begin
            $display("%0t: clipped mismatch: expected %0b, actual %0b",
                     $time, head_result.clipped, out_clipped);
            errors++;
          end
        end
      end
      if (want_hold && hold_cnt < HOLD_CYCLES) begin
        hold_cnt  <= hold_cnt + 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Watchdog: too long without a request getting through on either side ends
  // the run as a failure.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int n = 0; n <= ORDER; n++) begin
      feed_tap[n] = to_q26(FEED_NANO[n]);
      back_tap[n] = to_q26(BACK_NANO[n]);
    end
    for (int n = 0; n < ORDER; n++) begin
      x_hist[n] = '0;
      y_hist[n] = '0;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: zero, the smallest steps, both extremes, then a
    // full-scale square wave inside the pass band to push toward saturation.
    pending_samples.push_back(16'h0000);
    pending_samples.push_back(16'h0001);
    pending_samples.push_back(16'hffff);
    pending_samples.push_back(16'h7fff);
    pending_samples.push_back(16'h8000);
    pending_samples.push_back(16'h0000);
    for (int i = 0; i < 19; i++) begin
      pending_samples.push_back(((i % 12) < 6) ? 16'h7fff : 16'h8000);
    end
    wait_drained();

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender keeps offering samples.
    want_hold = 1'b1;
    queue_program(16);
    wait_drained();

    // Random phases. Each one drains fully before the next, so the sender
    // also sits idle until every result is back.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      tx_idle_pct  = TX_IDLE_PCT[ph];
      rx_stall_pct = RX_STALL_PCT[ph];
      queue_program(RANDOM_PER_PHASE);
      wait_drained();
    end

    // Give a stray extra result time to show up.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && expected_filtered.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[iir_band_pass_filter.f]
sv/ibpf_pkg.sv
sv/iir_band_pass_filter.sv
tb/tb_top.sv
